>>> sv/cpualu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpualu_pkg
// Shared types, command codes, flag positions and masks for the 8-bit
// accumulator ALU with binary and BCD arithmetic.
// ----------------------------------------------------------------------------
package cpualu_pkg;

   typedef enum logic [3:0] {
      CMD_ADC = 4'd0,
      CMD_SBC = 4'd1,
      CMD_AND = 4'd2,
      CMD_EOR = 4'd3,
      CMD_ORA = 4'd4,
      CMD_CMP = 4'd5,
      CMD_CPX = 4'd6,
      CMD_CPY = 4'd7,
      CMD_BIT = 4'd8,
      CMD_INC = 4'd9,
      CMD_DEC = 4'd10,
      CMD_INX = 4'd11,
      CMD_INY = 4'd12,
      CMD_DEX = 4'd13,
      CMD_DEY = 4'd14
   } cmd_type;

   // status byte bit positions
   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_D = 3;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   // bits kept before the new flags are merged in
   localparam logic [7:0] ARITH_KEEP_MASK = 8'b0011_1100;
   localparam logic [7:0] NZ_KEEP_MASK    = 8'b0111_1101;
   localparam logic [7:0] BIT_KEEP_MASK   = 8'b0011_1101;
   localparam logic [7:0] NV_MASK         = 8'hC0;

   // BCD digit correction
   localparam logic [4:0] BCD_LO_LIMIT = 5'h0A;
   localparam logic [3:0] BCD_LO_FIX   = 4'h6;
   localparam logic [8:0] BCD_HI_LIMIT = 9'h0A0;
   localparam logic [9:0] BCD_HI_FIX   = 10'h060;

   typedef struct packed {
      logic [3:0] command;
      logic [7:0] operand;
      logic [7:0] acc_in;
      logic [7:0] index_x_in;
      logic [7:0] index_y_in;
      logic [7:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [7:0] acc_out;
      logic [7:0] index_x_out;
      logic [7:0] index_y_out;
      logic [7:0] flags_out;
      logic [7:0] mem_out;
   } rsp_type;

   typedef struct packed {
      logic n;
      logic v;
      logic z;
      logic c;
   } arith_flags_type;

   // replace N and Z from a result byte, keep the rest
   function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] value);
      logic [7:0] r;
      r         = p & NZ_KEEP_MASK;
      r[FLAG_N] = value[7];
      r[FLAG_Z] = (value == 8'h00);
      return r;
   endfunction

endpackage

>>> sv/cpualu_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpualu_req_if
// Valid/ready channel carrying one ALU operation request.
// ----------------------------------------------------------------------------
interface cpualu_req_if;
   logic                valid;
   logic                ready;
   cpualu_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/cpualu_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpualu_rsp_if
// Valid/ready channel carrying one ALU result.
// ----------------------------------------------------------------------------
interface cpualu_rsp_if;
   logic                valid;
   logic                ready;
   cpualu_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/cpualu_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpualu_addsub
// ADC/SBC datapath: binary add with carry, plus BCD digit correction for
// decimal mode. Flags follow NMOS behavior.
// ----------------------------------------------------------------------------
module cpualu_addsub (
   input  logic                        sub_en,
   input  logic                        dec_en,
   input  logic                        carry_in,
   input  logic [7:0]                  acc,
   input  logic [7:0]                  opnd,
   output logic [7:0]                  result,
   output cpualu_pkg::arith_flags_type flags
);

   logic [7:0] opnd_eff;
   logic [8:0] bin_sum;
   logic       bin_v;

   // decimal add
   logic [4:0] adc_lo;
   logic [4:0] adc_lo_adj;
   logic [8:0] adc_hi;
   logic [9:0] adc_signed;
   logic [9:0] adc_fix;
   logic       adc_v;

   // decimal subtract
   logic [5:0] sbc_lo;
   logic [5:0] sbc_lo_adj;
   logic [3:0] sbc_lo_nib;
   logic [9:0] sbc_hi;
   logic [9:0] sbc_fix;

   // SBC is A + ~B + C in binary
   assign opnd_eff = sub_en ? ~opnd : opnd;
   assign bin_sum  = {1'b0, acc} + {1'b0, opnd_eff} + {8'h00, carry_in};
   assign bin_v    = (acc[7] == opnd_eff[7]) && (bin_sum[7] != acc[7]);

   always_comb begin
      adc_lo = {1'b0, acc[3:0]} + {1'b0, opnd[3:0]} + {4'h0, carry_in};
      if (adc_lo >= cpualu_pkg::BCD_LO_LIMIT) begin
         adc_lo_adj = {1'b1, adc_lo[3:0] + cpualu_pkg::BCD_LO_FIX};
      end else begin
         adc_lo_adj = adc_lo;
      end
      adc_hi = {1'b0, acc[7:4], 4'h0} + {1'b0, opnd[7:4], 4'h0} + {4'h0, adc_lo_adj};
      // high nibbles taken as signed for V
      adc_signed = {{2{acc[7]}}, acc[7:4], 4'h0} + {{2{opnd[7]}}, opnd[7:4], 4'h0}
                 + {5'h00, adc_lo_adj};
      adc_v = !((adc_signed[9:7] == 3'b000) || (adc_signed[9:7] == 3'b111));
      if (adc_hi >= cpualu_pkg::BCD_HI_LIMIT) begin
         adc_fix = {1'b0, adc_hi} + cpualu_pkg::BCD_HI_FIX;
      end else begin
         adc_fix = {1'b0, adc_hi};
      end
   end

   always_comb begin
      sbc_lo     = {2'b00, acc[3:0]} - {2'b00, opnd[3:0]} + {5'h00, carry_in} - 6'd1;
      sbc_lo_nib = sbc_lo[3:0] - cpualu_pkg::BCD_LO_FIX;
      // low borrow: corrected digit minus 16
      if (sbc_lo[5]) begin
         sbc_lo_adj = {2'b11, sbc_lo_nib};
      end else begin
         sbc_lo_adj = sbc_lo;
      end
      sbc_hi = {2'b00, acc[7:4], 4'h0} - {2'b00, opnd[7:4], 4'h0}
             + {{4{sbc_lo_adj[5]}}, sbc_lo_adj};
      if (sbc_hi[9]) begin
         sbc_fix = sbc_hi - cpualu_pkg::BCD_HI_FIX;
      end else begin
         sbc_fix = sbc_hi;
      end
   end

   always_comb begin
      flags.z = (bin_sum[7:0] == 8'h00);
      if (dec_en && !sub_en) begin
         result  = adc_fix[7:0];
         flags.n = adc_hi[7];
         flags.v = adc_v;
         flags.c = adc_fix[9] | adc_fix[8];
      end else begin
         result  = (dec_en && sub_en) ? sbc_fix[7:0] : bin_sum[7:0];
         flags.n = bin_sum[7];
         flags.v = bin_v;
         flags.c = bin_sum[8];
      end
   end

endmodule

>>> sv/cpualu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpualu_exec
// Single-pass execute logic: decodes the command and forms the new
// registers, status byte and memory write-back byte.
// ----------------------------------------------------------------------------
module cpualu_exec (
   input  cpualu_pkg::req_type req,
   output cpualu_pkg::rsp_type rsp
);

   logic [7:0]                  arith_result;
   cpualu_pkg::arith_flags_type arith_flags;
   logic                        sub_en;

   logic [7:0] and_val;
   logic [7:0] eor_val;
   logic [7:0] ora_val;
   logic [7:0] cmp_src;
   logic [8:0] cmp_diff;
   logic [7:0] step_src;
   logic       step_down;
   logic [7:0] step_val;

   assign sub_en = (req.command == cpualu_pkg::CMD_SBC);

   cpualu_addsub u_addsub (
      .sub_en   (sub_en),
      .dec_en   (req.flags_in[cpualu_pkg::FLAG_D]),
      .carry_in (req.flags_in[cpualu_pkg::FLAG_C]),
      .acc      (req.acc_in),
      .opnd     (req.operand),
      .result   (arith_result),
      .flags    (arith_flags)
   );

   assign and_val = req.acc_in & req.operand;
   assign eor_val = req.acc_in ^ req.operand;
   assign ora_val = req.acc_in | req.operand;

   always_comb begin
      case (cpualu_pkg::cmd_type'(req.command))
         cpualu_pkg::CMD_CPX: cmp_src = req.index_x_in;
         cpualu_pkg::CMD_CPY: cmp_src = req.index_y_in;
         default:             cmp_src = req.acc_in;
      endcase
   end
   assign cmp_diff = {1'b0, cmp_src} - {1'b0, req.operand};

   // one shared incrementer/decrementer for INC/DEC/INX/INY/DEX/DEY
   always_comb begin
      case (cpualu_pkg::cmd_type'(req.command))
         cpualu_pkg::CMD_INX, cpualu_pkg::CMD_DEX: step_src = req.index_x_in;
         cpualu_pkg::CMD_INY, cpualu_pkg::CMD_DEY: step_src = req.index_y_in;
         default:                                  step_src = req.operand;
      endcase
   end
   assign step_down = (req.command == cpualu_pkg::CMD_DEC) ||
                      (req.command == cpualu_pkg::CMD_DEX) ||
                      (req.command == cpualu_pkg::CMD_DEY);
   assign step_val  = step_src + (step_down ? 8'hFF : 8'h01);

   always_comb begin
      rsp.acc_out     = req.acc_in;
      rsp.index_x_out = req.index_x_in;
      rsp.index_y_out = req.index_y_in;
      rsp.flags_out   = req.flags_in;
      rsp.mem_out     = 8'h00;
      case (cpualu_pkg::cmd_type'(req.command))
         cpualu_pkg::CMD_ADC, cpualu_pkg::CMD_SBC: begin
            rsp.acc_out   = arith_result;
            rsp.flags_out = req.flags_in & cpualu_pkg::ARITH_KEEP_MASK;
            rsp.flags_out[cpualu_pkg::FLAG_N] = arith_flags.n;
            rsp.flags_out[cpualu_pkg::FLAG_V] = arith_flags.v;
            rsp.flags_out[cpualu_pkg::FLAG_Z] = arith_flags.z;
            rsp.flags_out[cpualu_pkg::FLAG_C] = arith_flags.c;
         end
         cpualu_pkg::CMD_AND: begin
            rsp.acc_out   = and_val;
            rsp.flags_out = cpualu_pkg::set_nz(req.flags_in, and_val);
         end
         cpualu_pkg::CMD_EOR: begin
            rsp.acc_out   = eor_val;
            rsp.flags_out = cpualu_pkg::set_nz(req.flags_in, eor_val);
         end
         cpualu_pkg::CMD_ORA: begin
            rsp.acc_out   = ora_val;
            rsp.flags_out = cpualu_pkg::set_nz(req.flags_in, ora_val);
         end
         cpualu_pkg::CMD_CMP, cpualu_pkg::CMD_CPX, cpualu_pkg::CMD_CPY: begin
            rsp.flags_out = cpualu_pkg::set_nz(req.flags_in, cmp_diff[7:0]);
            // carry is unsigned no-borrow
            rsp.flags_out[cpualu_pkg::FLAG_C] = !cmp_diff[8];
         end
         cpualu_pkg::CMD_BIT: begin
            rsp.flags_out = (req.flags_in & cpualu_pkg::BIT_KEEP_MASK)
                          | (req.operand & cpualu_pkg::NV_MASK);
            rsp.flags_out[cpualu_pkg::FLAG_Z] = (and_val == 8'h00);
         end
         cpualu_pkg::CMD_INC, cpualu_pkg::CMD_DEC: begin
            rsp.mem_out   = step_val;
            rsp.flags_out = cpualu_pkg::set_nz(req.flags_in, step_val);
         end
         cpualu_pkg::CMD_INX, cpualu_pkg::CMD_DEX: begin
            rsp.index_x_out = step_val;
            rsp.flags_out   = cpualu_pkg::set_nz(req.flags_in, step_val);
         end
         cpualu_pkg::CMD_INY, cpualu_pkg::CMD_DEY: begin
            rsp.index_y_out = step_val;
            rsp.flags_out   = cpualu_pkg::set_nz(req.flags_in, step_val);
         end
         default: begin
            // unused code: pass everything through
            rsp.mem_out = 8'h00;
         end
      endcase
   end

endmodule

>>> sv/cpu_alu_with_decimal_mode.sv
`timescale 1ns / 1ps
// Path: request transfer -> input register -> execute logic -> result register.
// Throughput: one operation per cycle while responses are accepted; the input
// register refills while the result register drains, so both stages advance
// together. A stalled response holds the result register; the input stage
// stalls only once it is occupied as well.
// Reset (synchronous, active high) empties both stages; no other state.
// ----------------------------------------------------------------------------
// cpu_alu_with_decimal_mode
// 8-bit accumulator-machine ALU with BCD ADC/SBC: input register, execute
// logic, result register, valid/ready on both sides.
// ----------------------------------------------------------------------------
module cpu_alu_with_decimal_mode (
   input  logic                clock,
   input  logic                reset,
   cpualu_req_if.sink          req_ch,
   cpualu_rsp_if.source        rsp_ch
);

   logic                in_valid_ff;
   logic                in_valid_in;
   cpualu_pkg::req_type in_data_ff;
   cpualu_pkg::req_type in_data_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   cpualu_pkg::rsp_type rsp_data_ff;
   cpualu_pkg::rsp_type rsp_data_in;
   cpualu_pkg::rsp_type core_rsp;

   logic out_free;
   logic in_free;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign in_free  = !in_valid_ff || out_free;

   assign req_ch.ready = in_free;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   cpualu_exec u_exec (
      .req (in_data_ff),
      .rsp (core_rsp)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (in_free) begin
         in_valid_in = req_ch.valid;
         if (req_ch.valid) begin
            in_data_in = req_ch.data;
         end
      end
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            rsp_data_in = core_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a request transfer always lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> in_valid_ff)
      else $error("request transfer lost at input stage");

   // an occupied input stage moves on whenever the result stage frees up
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> rsp_valid_ff)
      else $error("input stage did not advance to result stage");

   // result stage takes exactly the execute output
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> rsp_data_ff == $past(core_rsp))
      else $error("result register does not match execute output");

   // write-back byte only for INC and DEC
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (in_data_ff.command != cpualu_pkg::CMD_INC)
                  && (in_data_ff.command != cpualu_pkg::CMD_DEC)
      |-> core_rsp.mem_out == 8'h00)
      else $error("mem_out nonzero for a non INC/DEC command");

   // X changes only on INX or DEX
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (core_rsp.index_x_out != in_data_ff.index_x_in)
      |-> (in_data_ff.command == cpualu_pkg::CMD_INX) ||
          (in_data_ff.command == cpualu_pkg::CMD_DEX))
      else $error("X modified by a command that does not write it");

   // reset empties both stages
   assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
